>>> design/cfe_pkg.sv
// Shared constants and control types for the COBS frame encoder.
package cfe_pkg;

    localparam int BYTE_W    = 8;
    localparam int WORD_W    = 64;
    localparam int LANE_IX_W = 3;
    localparam int CNT_W     = 4;
    localparam int LEN_W     = 8;
    localparam int BLOCK_MAX = 254;
    localparam int MAX_WORDS = 33;
    localparam int WCNT_W    = 6;

    // Byte source selected for the packer.
    localparam logic [1:0] SRC_DELIM = 2'd0;
    localparam logic [1:0] SRC_CODE  = 2'd1;
    localparam logic [1:0] SRC_BUF   = 2'd2;

    typedef struct packed {
        logic       accept;
        logic       store;
        logic       push;
        logic [1:0] src;
        logic       open_frame;
        logic       close_frame;
        logic       clear_len;
        logic       flush;
    } t_cmd;

    typedef struct packed {
        logic frame_open;
        logic byte_is_delim;
        logic eom;
        logic will_fill;
        logic len_zero;
        logic buf_last;
        logic push_ok;
        logic flush_ok;
        logic pkt_empty;
    } t_status;

endpackage

>>> design/cfe_ctrl.sv
// Sequencing state machine of the COBS frame encoder.
module cfe_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    input  cfe_pkg::t_status i_status,
    output cfe_pkg::t_cmd   o_cmd,
    output logic            o_busy
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_LEAD   = 3'd1;
    localparam logic [2:0] S_DECIDE = 3'd2;
    localparam logic [2:0] S_CODE   = 3'd3;
    localparam logic [2:0] S_BUF    = 3'd4;
    localparam logic [2:0] S_TRAIL  = 3'd5;
    localparam logic [2:0] S_FLUSH  = 3'd6;

    logic [2:0] r_state, n_state;
    // Set while the block being sent is the one closed by the end of the message.
    logic       r_eom_close, n_eom_close;
    logic       block_end;

    always_comb begin
        n_state     = r_state;
        n_eom_close = r_eom_close;
        o_cmd       = '0;
        block_end   = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_eom_close  = 1'b0;
                    n_state      = i_status.frame_open ? S_DECIDE : S_LEAD;
                end
            end
            S_LEAD: begin
                o_cmd.push = 1'b1;
                o_cmd.src  = cfe_pkg::SRC_DELIM;
                if (i_status.push_ok) begin
                    o_cmd.open_frame = 1'b1;
                    n_state          = S_DECIDE;
                end
            end
            S_DECIDE: begin
                if (i_status.byte_is_delim) begin
                    n_state = S_CODE;
                end else begin
                    o_cmd.store = 1'b1;
                    if (i_status.will_fill) begin
                        n_state = S_CODE;
                    end else if (i_status.eom) begin
                        n_eom_close = 1'b1;
                        n_state     = S_CODE;
                    end else if (i_status.pkt_empty) begin
                        n_state = S_IDLE;
                    end else begin
                        n_state = S_FLUSH;
                    end
                end
            end
            S_CODE: begin
                o_cmd.push = 1'b1;
                o_cmd.src  = cfe_pkg::SRC_CODE;
                if (i_status.push_ok) begin
                    if (i_status.len_zero) begin
                        block_end = 1'b1;
                    end else begin
                        n_state = S_BUF;
                    end
                end
            end
            S_BUF: begin
                o_cmd.push = 1'b1;
                o_cmd.src  = cfe_pkg::SRC_BUF;
                if (i_status.push_ok && i_status.buf_last) begin
                    block_end = 1'b1;
                end
            end
            S_TRAIL: begin
                o_cmd.push = 1'b1;
                o_cmd.src  = cfe_pkg::SRC_DELIM;
                if (i_status.push_ok) begin
                    o_cmd.close_frame = 1'b1;
                    n_state           = S_FLUSH;
                end
            end
            S_FLUSH: begin
                o_cmd.flush = 1'b1;
                if (i_status.flush_ok) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (block_end) begin
            o_cmd.clear_len = 1'b1;
            if (r_eom_close) begin
                n_state = S_TRAIL;
            end else if (i_status.eom) begin
                n_eom_close = 1'b1;
                n_state     = S_CODE;
            end else begin
                n_state = S_FLUSH;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_eom_close <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_eom_close <= n_eom_close;
        end
    end

    assign o_busy = (r_state != S_IDLE);

endmodule

>>> design/cfe_dpath.sv
// Datapath of the COBS frame encoder: block buffer, byte packer and output register.
module cfe_dpath #(
    parameter int OUT_LANES = 8
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  cfe_pkg::t_cmd                i_cmd,
    output cfe_pkg::t_status             o_status,
    input  logic                         i_cfg_wr_en,
    input  logic [cfe_pkg::BYTE_W-1:0]   i_cfg_wr_data,
    input  logic [cfe_pkg::BYTE_W-1:0]   i_data_byte,
    input  logic                         i_end_of_message,
    input  logic                         i_out_stall,
    output logic                         o_out_valid,
    output logic [cfe_pkg::WORD_W-1:0]   o_out_bytes,
    output logic [cfe_pkg::CNT_W-1:0]    o_byte_count,
    output logic                         o_last_of_run,
    output logic                         o_end_of_frame
);

    localparam logic [cfe_pkg::CNT_W-1:0]  LANES_C = cfe_pkg::CNT_W'(OUT_LANES);
    localparam logic [cfe_pkg::WCNT_W-1:0] WCAP_C  = cfe_pkg::WCNT_W'(cfe_pkg::MAX_WORDS - 1);
    localparam logic [cfe_pkg::LEN_W-1:0]  FILL_C  = cfe_pkg::LEN_W'(cfe_pkg::BLOCK_MAX - 1);

    logic [cfe_pkg::BYTE_W-1:0] r_delim;
    logic [cfe_pkg::BYTE_W-1:0] r_byte;
    logic                       r_eom;
    logic [cfe_pkg::LEN_W-1:0]  r_len;
    logic                       r_open;
    logic [cfe_pkg::LEN_W-1:0]  r_idx;
    logic [cfe_pkg::BYTE_W-1:0] r_rd_data;
    logic [cfe_pkg::BYTE_W-1:0] mem [cfe_pkg::BLOCK_MAX];

    logic [cfe_pkg::WORD_W-1:0] r_word;
    logic [cfe_pkg::CNT_W-1:0]  r_cnt;
    logic [cfe_pkg::WCNT_W-1:0] r_words;
    logic                       r_drop;

    logic                       r_out_valid;
    logic [cfe_pkg::WORD_W-1:0] r_out_bytes;
    logic [cfe_pkg::CNT_W-1:0]  r_out_cnt;
    logic                       r_out_last;
    logic                       r_out_eof;

    logic                       out_free;
    logic                       word_full;
    logic                       at_cap;
    logic                       push_ok;
    logic                       do_push;
    logic                       emit_push;
    logic                       emit_flush;
    logic [cfe_pkg::BYTE_W-1:0] push_byte;
    logic                       rd_en;
    logic [cfe_pkg::LEN_W-1:0]  rd_addr;

    assign out_free   = !r_out_valid || !i_out_stall;
    assign word_full  = (r_cnt == LANES_C);
    // The word in the packer is the last one a single item may produce.
    assign at_cap     = (r_words == WCAP_C);
    assign push_ok    = !word_full || out_free || at_cap;
    assign do_push    = i_cmd.push && push_ok;
    assign emit_push  = do_push && word_full && !at_cap;
    assign emit_flush = i_cmd.flush && (r_cnt != '0) && out_free;

    always_comb begin
        case (i_cmd.src)
            cfe_pkg::SRC_DELIM: push_byte = r_delim;
            cfe_pkg::SRC_CODE:  push_byte = r_delim + 8'd1 + r_len;
            cfe_pkg::SRC_BUF:   push_byte = r_rd_data;
            default:            push_byte = r_delim;
        endcase
    end

    assign rd_addr = (i_cmd.src == cfe_pkg::SRC_CODE) ? '0 : r_idx + 8'd1;
    assign rd_en   = do_push && ((i_cmd.src == cfe_pkg::SRC_CODE) ||
                                 (i_cmd.src == cfe_pkg::SRC_BUF)) && (rd_addr < r_len);

    // Block buffer: entries are only ever read below the fill count.
    always_ff @(posedge i_clk) begin
        if (i_cmd.store) begin
            mem[r_len] <= r_byte;
        end
        if (rd_en) begin
            r_rd_data <= mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_byte <= i_data_byte;
            r_eom  <= i_end_of_message;
        end
        if (do_push && (i_cmd.src == cfe_pkg::SRC_CODE)) begin
            r_idx <= '0;
        end else if (do_push && (i_cmd.src == cfe_pkg::SRC_BUF)) begin
            r_idx <= r_idx + 8'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_delim <= '0;
            r_len   <= '0;
            r_open  <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_delim <= i_cfg_wr_data;
            end
            if (i_cmd.clear_len) begin
                r_len <= '0;
            end else if (i_cmd.store) begin
                r_len <= r_len + 8'd1;
            end
            if (i_cmd.open_frame) begin
                r_open <= 1'b1;
            end else if (i_cmd.close_frame) begin
                r_open <= 1'b0;
            end
        end
    end

    // Byte packer: a full word is held until the next byte or the end of the item.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_word  <= '0;
            r_cnt   <= '0;
            r_words <= '0;
            r_drop  <= 1'b0;
        end else begin
            if (i_cmd.accept) begin
                r_words <= '0;
                r_drop  <= 1'b0;
            end
            if (do_push) begin
                if (word_full) begin
                    if (at_cap) begin
                        r_drop <= 1'b1;
                    end else begin
                        r_word  <= {{(cfe_pkg::WORD_W - cfe_pkg::BYTE_W){1'b0}}, push_byte};
                        r_cnt   <= 4'd1;
                        r_words <= r_words + 6'd1;
                    end
                end else begin
                    r_word[cfe_pkg::BYTE_W * r_cnt[cfe_pkg::LANE_IX_W-1:0] +: cfe_pkg::BYTE_W]
                        <= push_byte;
                    r_cnt <= r_cnt + 4'd1;
                end
            end else if (emit_flush) begin
                r_word <= '0;
                r_cnt  <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit_push || emit_flush) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit_push || emit_flush) begin
            r_out_bytes <= r_word;
            r_out_cnt   <= r_cnt;
            r_out_last  <= emit_flush;
            r_out_eof   <= emit_flush && r_eom && !r_drop;
        end
    end

    assign o_status.frame_open    = r_open;
    assign o_status.byte_is_delim = (r_byte == r_delim);
    assign o_status.eom           = r_eom;
    assign o_status.will_fill     = (r_len == FILL_C);
    assign o_status.len_zero      = (r_len == '0);
    assign o_status.buf_last      = (r_idx == r_len - 8'd1);
    assign o_status.push_ok       = push_ok;
    assign o_status.flush_ok      = (r_cnt == '0) || out_free;
    assign o_status.pkt_empty     = (r_cnt == '0);

    assign o_out_valid    = r_out_valid;
    assign o_out_bytes    = r_out_bytes;
    assign o_byte_count   = r_out_cnt;
    assign o_last_of_run  = r_out_last;
    assign o_end_of_frame = r_out_eof;

endmodule

>>> design/cobs_frame_encoder_top.sv
// Top level of the COBS frame encoder: controller, datapath and checks.
//
// Message bytes enter one item at a time on the input channel, the final byte
// of each message flagged by i_end_of_message. Each message is framed as COBS:
// a leading delimiter, blocks made of a code byte (delimiter + 1 + block
// length, modulo 256) and the block's non-delimiter bytes, then a trailing
// delimiter. A delimiter byte in the message is dropped and closes its block;
// a run of 254 bytes closes a full block with code delimiter + 255 that
// implies no delimiter. Results leave as words of up to OUT_LANES bytes, the
// first byte in the least significant byte and unused bytes zero, with a byte
// count; o_last_of_run marks the last word caused by an item and
// o_end_of_frame the word holding the trailing delimiter. The delimiter is
// set through i_cfg_wr_en/i_cfg_wr_data and must be written only while the
// block is idle; the block itself does not enforce this. An item that closes
// no block and ends no message is accepted and then decided on; the leading
// delimiter of a frame adds a push ahead of the decision, and when its item
// closes no block a flush hands over the word that holds it. Every closed
// block is read out of the 254-byte block buffer one byte per cycle while no
// full word waits on a stalled output. A close pushes the code byte and each
// stored byte, at a message end the trailing delimiter, and a flush the last
// word. Output stalls stretch this. The block buffer needs no clearing after
// reset, since only entries below the current fill count are read.
module cobs_frame_encoder_top #(
    parameter int OUT_LANES = 8
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_wr_en,
    input  logic [cfe_pkg::BYTE_W-1:0]   i_cfg_wr_data,
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic [cfe_pkg::BYTE_W-1:0]   i_data_byte,
    input  logic                         i_end_of_message,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic [cfe_pkg::WORD_W-1:0]   o_out_bytes,
    output logic [cfe_pkg::CNT_W-1:0]    o_byte_count,
    output logic                         o_last_of_run,
    output logic                         o_end_of_frame
);

    cfe_pkg::t_cmd    cmd;
    cfe_pkg::t_status status;
    logic             busy;
    logic             in_accept;

    // The input side is held off for the whole of an item's work.
    assign o_in_stall = busy;
    assign in_accept  = i_in_valid && !o_in_stall;

    cfe_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_status   (status),
        .o_cmd      (cmd),
        .o_busy     (busy)
    );

    cfe_dpath #(
        .OUT_LANES (OUT_LANES)
    ) u_dpath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_status         (status),
        .i_cfg_wr_en      (i_cfg_wr_en),
        .i_cfg_wr_data    (i_cfg_wr_data),
        .i_data_byte      (i_data_byte),
        .i_end_of_message (i_end_of_message),
        .i_out_stall      (i_out_stall),
        .o_out_valid      (o_out_valid),
        .o_out_bytes      (o_out_bytes),
        .o_byte_count     (o_byte_count),
        .o_last_of_run    (o_last_of_run),
        .o_end_of_frame   (o_end_of_frame)
    );

`ifndef SYNTH
    // The trailing delimiter always sits in the last word of its item.
    a_eof_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_end_of_frame |-> o_last_of_run)
        else $error("end of frame on a word that is not the last of its item");

    // Every word carries between one and OUT_LANES bytes.
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_byte_count != '0) &&
                        (o_byte_count <= cfe_pkg::CNT_W'(OUT_LANES)))
        else $error("byte count out of range");

    // An accepted item keeps the input side held off in the following cycle.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> o_in_stall)
        else $error("input not held off after an item was accepted");
`endif

endmodule

>>> test/testbench.sv
// Self-checking testbench for the COBS frame encoder top level.
module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int LANES         = 8;
    // Quiet period after the last expected word, so that an item which
    // produces no word has left the block before the delimiter changes.
    localparam int SETTLE_CYCLES = 16;
    // Long enough for a block flush under heavy output stalling and
    // for the deliberate receiver hold-off below, with a wide margin.
    localparam int IDLE_LIMIT    = 6000;
    localparam int HOLD_CYCLES   = 400;
    localparam int MAX_REPORTS   = 10;

    // One message byte as offered on the input channel.
    typedef struct packed {
        logic [cfe_pkg::BYTE_W-1:0] data;
        logic                       eom;
    } t_msg_item;

    // One encoded output word, in the field order of the output ports.
    typedef struct packed {
        logic [cfe_pkg::WORD_W-1:0] bytes;
        logic [cfe_pkg::CNT_W-1:0]  count;
        logic                       last;
        logic                       eof;
    } t_word;

    logic                        i_clk;
    logic                        rst_n       = 1'b0;
    logic                        cfg_wr_en   = 1'b0;
    logic [cfe_pkg::BYTE_W-1:0]  cfg_wr_data = '0;
    logic                        in_valid    = 1'b0;
    logic [cfe_pkg::BYTE_W-1:0]  in_data     = '0;
    logic                        in_eom      = 1'b0;
    logic                        out_stall   = 1'b0;

    logic                        o_in_stall;
    logic                        o_out_valid;
    logic [cfe_pkg::WORD_W-1:0]  o_out_bytes;
    logic [cfe_pkg::CNT_W-1:0]   o_byte_count;
    logic                        o_last_of_run;
    logic                        o_end_of_frame;

    // Message bytes waiting to be offered, and encoded words still owed.
    t_msg_item                   pending[$];
    t_word                       expected_words[$];

    // Shadow of the encoder: current delimiter, open block and frame flag.
    logic [cfe_pkg::BYTE_W-1:0]  enc_delim = '0;
    logic [cfe_pkg::BYTE_W-1:0]  blk_buf [0:cfe_pkg::BLOCK_MAX-1];
    int                          blk_len   = 0;
    logic                        frm_open  = 1'b0;
    logic [cfe_pkg::BYTE_W-1:0]  step_bytes[$];

    // Idling percentages for the current phase, and the hold-off request.
    int                          send_idle_pct = 0;
    int                          stall_pct     = 0;
    logic [3:0]                  hold_token    = '0;
    logic [3:0]                  hold_seen     = '0;
    int                          hold_left     = 0;

    int                          err_count  = 0;
    int                          idle_count = 0;

    cobs_frame_encoder_top #(
        .OUT_LANES(LANES)
    ) i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (rst_n),
        .i_cfg_wr_en     (cfg_wr_en),
        .i_cfg_wr_data   (cfg_wr_data),
        .i_in_valid      (in_valid),
        .o_in_stall      (o_in_stall),
        .i_data_byte     (in_data),
        .i_end_of_message(in_eom),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (out_stall),
        .o_out_bytes     (o_out_bytes),
        .o_byte_count    (o_byte_count),
        .o_last_of_run   (o_last_of_run),
        .o_end_of_frame  (o_end_of_frame)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Appends one byte to the bytes produced by the current step.
    function automatic void add_step_byte(input logic [cfe_pkg::BYTE_W-1:0] b);
        step_bytes.insert(step_bytes.size(), b);
    endfunction

    // Closing a block appends its code byte and the bytes held so far. A
    // full block passes 254 as its length, which yields delimiter + 255.
    function automatic void close_block(input logic [cfe_pkg::BYTE_W-1:0] code_len);
        logic [cfe_pkg::BYTE_W-1:0] code;
        code = enc_delim + 8'd1 + code_len;
        add_step_byte(code);
        for (int i = 0; i < blk_len; i++)
            add_step_byte(blk_buf[i]);
        blk_len = 0;
    endfunction

    // Encodes one accepted message byte and queues the words it produces.
    // The bytes of the step are gathered first and then packed into words
    // of up to LANES bytes, the first byte in the lowest lane.
    function automatic void encode_item(input logic [cfe_pkg::BYTE_W-1:0] data,
                                        input logic eom);
        t_word w;
        int    n;
        step_bytes.delete();
        // The leading delimiter goes out ahead of anything else in a frame.
        if (!frm_open) begin
            add_step_byte(enc_delim);
            frm_open = 1'b1;
        end
        if (data == enc_delim) begin
            // A delimiter in the message is dropped and closes the block.
            close_block(cfe_pkg::BYTE_W'(blk_len));
        end else begin
            blk_buf[blk_len] = data;
            blk_len++;
            // A run of 254 bytes closes a full block that implies no delimiter.
            if (blk_len == cfe_pkg::BLOCK_MAX)
                close_block(8'd254);
        end
        // The last block always closes at the end of a message, even when it
        // is empty, and the trailing delimiter follows it.
        if (eom) begin
            close_block(cfe_pkg::BYTE_W'(blk_len));
            add_step_byte(enc_delim);
            frm_open = 1'b0;
        end
        while (step_bytes.size() != 0) begin
            w = '0;
            n = 0;
            while (n < LANES && step_bytes.size() != 0) begin
                w.bytes[8*n +: 8] = step_bytes.pop_front();
                n++;
            end
            w.count = cfe_pkg::CNT_W'(n);
            w.last  = (step_bytes.size() == 0);
            w.eof   = eom && (step_bytes.size() == 0);
            expected_words.insert(expected_words.size(), w);
        end
    endfunction

    function automatic void queue_item(input logic [cfe_pkg::BYTE_W-1:0] data,
                                       input logic eom);
        t_msg_item it;
        it.data = data;
        it.eom  = eom;
        pending.insert(pending.size(), it);
    endfunction

    // Random message bytes: a share of them equal the current delimiter so
    // that blocks close often, and a share end their message.
    function automatic void queue_random(input int count, input int delim_pct,
                                         input int eom_pct);
        logic [cfe_pkg::BYTE_W-1:0] b;
        for (int i = 0; i < count; i++) begin
            if ($urandom_range(99) < delim_pct)
                b = enc_delim;
            else
                b = cfe_pkg::BYTE_W'($urandom_range(255));
            queue_item(b, $urandom_range(99) < eom_pct);
        end
    endfunction

    // The delimiter is only ever written while the block is idle, so the
    // shadow copy can take the new value straight away.
    task automatic write_delimiter(input logic [cfe_pkg::BYTE_W-1:0] value);
        @(posedge i_clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge i_clk);
        cfg_wr_en   <= 1'b0;
        enc_delim = value;
    endtask

    // Waits until every queued item has been taken and every owed word has
    // arrived. Polling on the falling edge keeps clear of the updates made
    // at the rising edge.
    task automatic drain;
        while (pending.size() != 0 || in_valid || expected_words.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Input driver. An item offered stays on the port, unchanged, until it
    // is accepted; only then does the next one (or an idle cycle) follow.
    // Each accepted item is handed to the shadow encoder at that same edge.
    always @(posedge i_clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && !o_in_stall)
                encode_item(in_data, in_eom);
            if (!in_valid || !o_in_stall) begin
                if (pending.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    t_msg_item it;
                    it = pending.pop_front();
                    in_valid <= 1'b1;
                    in_data  <= it.data;
                    in_eom   <= it.eom;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Output stall. A new hold-off request stalls the output for a long,
    // counted stretch; otherwise the stall follows the phase's percentage.
    always @(posedge i_clk) begin
        if (hold_token != hold_seen) begin
            hold_seen <= hold_token;
            hold_left <= HOLD_CYCLES;
            out_stall <= 1'b1;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            out_stall <= 1'b1;
        end else begin
            out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    // Output monitor: every accepted word is checked against the oldest
    // owed word, field by field.
    always @(posedge i_clk) begin
        if (rst_n && o_out_valid && !out_stall) begin
            if (expected_words.size() == 0) begin
                err_count++;
                if (err_count <= MAX_REPORTS)
                    $display("Unexpected word: bytes=%h count=%0d last=%b eof=%b",
                             o_out_bytes, o_byte_count, o_last_of_run, o_end_of_frame);
            end else begin
                t_word w;
                w = expected_words.pop_front();
                if (o_out_bytes !== w.bytes || o_byte_count !== w.count ||
                    o_last_of_run !== w.last || o_end_of_frame !== w.eof) begin
                    err_count++;
                    if (err_count <= MAX_REPORTS) begin
                        $write("Word mismatch: expected bytes=%h count=%0d last=%b eof=%b,",
                               w.bytes, w.count, w.last, w.eof);
                        $display(" got bytes=%h count=%0d last=%b eof=%b",
                                 o_out_bytes, o_byte_count, o_last_of_run,
                                 o_end_of_frame);
                    end
                end
            end
        end
    end

    // Watchdog: ends the run if nothing moves on either channel for too long.
    always @(posedge i_clk) begin
        if ((in_valid && !o_in_stall) || (o_out_valid === 1'b1 && !out_stall))
            idle_count <= 0;
        else
            idle_count <= idle_count + 1;
        if (idle_count == IDLE_LIMIT) begin
            $display("FAILED: results differ");
            $finish;
        end
    end

    initial begin
        repeat (6) @(posedge i_clk);
        rst_n <= 1'b1;

        // Directed messages with the default delimiter and no idling: a
        // delimiter-only message, extreme byte values, a delimiter closing a
        // block mid-message, and a message made of nothing but delimiters.
        write_delimiter(8'h00);
        queue_item(8'h00, 1'b1);
        queue_item(8'hFF, 1'b1);
        queue_item(8'h11, 1'b0);
        queue_item(8'h00, 1'b0);
        queue_item(8'h22, 1'b0);
        queue_item(8'h33, 1'b1);
        queue_item(8'h80, 1'b0);
        queue_item(8'h7F, 1'b0);
        queue_item(8'h01, 1'b0);
        queue_item(8'hFE, 1'b1);
        queue_item(8'h00, 1'b0);
        queue_item(8'h00, 1'b0);
        queue_item(8'h00, 1'b1);
        queue_item(8'hAA, 1'b0);
        queue_item(8'h55, 1'b1);
        drain();

        // Highest delimiter, so that code bytes wrap; the sender mostly idles.
        // Phases may end in the middle of a frame, so the next delimiter
        // change lands with bytes still held in the block buffer.
        write_delimiter(8'hFF);
        send_idle_pct = 86;
        queue_item(8'hFF, 1'b1);
        queue_item(8'h00, 1'b1);
        queue_random(20, 25, 20);
        drain();

        // A random delimiter with the receiver stalling most of the time.
        write_delimiter(cfe_pkg::BYTE_W'($urandom_range(255)));
        send_idle_pct = 0;
        stall_pct     = 86;
        queue_random(25, 25, 20);
        drain();

        // Both sides idle now and then.
        write_delimiter(8'h01);
        send_idle_pct = 19;
        stall_pct     = 19;
        queue_random(25, 25, 20);
        drain();

        // Back pressure: the receiver holds off for a long stretch while the
        // sender keeps offering short blocks, so the block fills and stalls
        // its input. The drain afterwards is the sender's pause until every
        // owed word has come.
        write_delimiter(8'h00);
        send_idle_pct = 0;
        stall_pct     = 0;
        @(posedge i_clk);
        hold_token <= hold_token + 4'd1;
        queue_random(30, 40, 15);
        drain();

        if (err_count == 0 && expected_words.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
